FILE: rtl/core/stp_pkg.sv
// Shared types and constants for the timer pool.
package stp_pkg;

	localparam int TimerCount = 8;
	localparam int SlotW = 3;
	localparam int HandleW = 4;
	localparam logic [31:0] DevSeconds = 32'd5;
	localparam logic [31:0] MsPerSecond = 32'd1000;
	// floor(x / 1000) == (x * MsRecip) >> MsRecipShift for every 32-bit x
	localparam logic [31:0] MsRecip = 32'd274877907;
	localparam int MsRecipShift = 38;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_RUNNING = 2'd1,
		ST_PAUSED  = 2'd2
	} slot_state_t;

	typedef enum logic [2:0] {
		FN_TICK   = 3'd0,
		FN_OPEN   = 3'd1,
		FN_PAUSE  = 3'd2,
		FN_RESUME = 3'd3,
		FN_STOP   = 3'd4,
		FN_CANCEL = 3'd5
	} func_t;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusBad = 2'd1;
	localparam logic [1:0] StatusNoFree = 2'd2;

	localparam logic [1:0] RegTicks = 2'd0;
	localparam logic [1:0] RegMode = 2'd1;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DIV,
		FSM_MUL,
		FSM_SCAN,
		FSM_APPLY,
		FSM_REPLY,
		FSM_EVENT
	} fsm_t;

	// Operation driven from the controller into every cell.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_SCAN,
		OP_WRITE_NEW,
		OP_RESTART,
		OP_SET_STATE,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [SlotW-1:0] sel;
		slot_state_t state;
		logic [15:0] key;
		logic [31:0] delay;
		logic [31:0] timeout;
		logic [31:0] tick;
		logic        prod;
	} cell_cmd_t;

	// Slot record shifted along the chain during a scan.
	typedef struct packed {
		slot_state_t state;
		logic [15:0] client;
		logic [31:0] timeout;
		logic [31:0] start;
	} cell_view_t;

endpackage

FILE: rtl/core/stp_cell.sv
// One timer slot; in a scan the records rotate one cell per cycle.
module stp_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stp_pkg::cell_cmd_t  cmd,
	input  logic [stp_pkg::SlotW-1:0] idx,
	input  stp_pkg::cell_view_t prev,
	input  logic [stp_pkg::SlotW-1:0] prev_id,
	output stp_pkg::cell_view_t view,
	output logic [stp_pkg::SlotW-1:0] view_id
);

	stp_pkg::cell_view_t v_q;
	logic [stp_pkg::SlotW-1:0] id_q;
	logic [31:0] delay_q;

	assign view = v_q;
	assign view_id = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '{state: stp_pkg::ST_IDLE, client: '0, timeout: '0, start: '0};
			id_q <= idx;
			delay_q <= '0;
		end else begin
			case (cmd.op)
				stp_pkg::OP_SCAN: begin
					v_q <= prev;
					id_q <= prev_id;
				end
				stp_pkg::OP_WRITE_NEW: if (id_q == cmd.sel) begin
					v_q.state <= stp_pkg::ST_RUNNING;
					v_q.client <= cmd.key;
					v_q.timeout <= cmd.timeout;
					v_q.start <= cmd.tick;
					delay_q <= cmd.delay;
				end
				stp_pkg::OP_RESTART: if (id_q == cmd.sel) begin
					v_q.state <= stp_pkg::ST_RUNNING;
					v_q.start <= cmd.tick;
				end
				stp_pkg::OP_SET_STATE: if (id_q == cmd.sel) begin
					v_q.state <= cmd.state;
				end
				stp_pkg::OP_CLEAR: if (id_q == cmd.sel) begin
					v_q <= '{state: stp_pkg::ST_IDLE, client: '0, timeout: '0, start: '0};
					delay_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	logic unused_delay;
	assign unused_delay = ^{delay_q, cmd.prod};

endmodule

FILE: rtl/core/stp_ctrl.sv
// Sequencer: decodes a request, walks the cell chain and emits results.
module stp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [59:0]         s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [9:0]          m_tdata,
	output logic                m_tlast,
	output logic                m_tuser,
	input  logic [31:0]         ticks_per_second,
	input  logic                prod,
	input  stp_pkg::cell_view_t head,
	input  logic [stp_pkg::SlotW-1:0] head_id,
	input  stp_pkg::cell_view_t sel_view,
	output stp_pkg::cell_cmd_t  cmd,
	output logic [stp_pkg::SlotW-1:0] sel_idx
);

	stp_pkg::fsm_t st_q, st_d;
	logic [2:0]  func_q;
	logic [31:0] delay_q, tick_q, quot_q;
	logic [15:0] key_q;
	logic [3:0]  hnd_q, si_q;
	logic [5:0]  cnt_q;
	logic        mode_q;
	logic        hit_q, idle_q;
	logic [2:0]  hit_slot_q, idle_slot_q;
	logic [7:0]  due_q;
	logic [1:0]  status_q;
	logic [3:0]  rh_q;
	logic [31:0] timeout_q;
	logic [2:0]  ev_slot;
	logic        more_ev;
	logic [63:0] recip_prod;

	// Slot selected for single-slot commands.
	always_comb begin
		sel_idx = hnd_q[2:0] - 3'd1;
		if (func_q == stp_pkg::FN_STOP)
			sel_idx = si_q[2:0];
	end

	logic hnd_ok, si_ok;
	assign hnd_ok = (hnd_q != 4'd0) && (hnd_q <= 4'(stp_pkg::TimerCount));
	assign si_ok = (si_q < 4'(stp_pkg::TimerCount));

	// Next expiry in ascending slot order.
	always_comb begin
		ev_slot = '0;
		more_ev = 1'b0;
		for (int i = stp_pkg::TimerCount - 1; i >= 0; i--) begin
			if (due_q[i]) begin
				ev_slot = 3'(i);
			end
		end
		more_ev = ($countones(due_q) > 1);
	end

	// whole seconds of the delay by reciprocal multiplication
	assign recip_prod = 64'(delay_q) * 64'(stp_pkg::MsRecip);
	assign s_tready = (st_q == stp_pkg::FSM_IDLE);

	always_comb begin
		st_d = st_q;
		cmd = '0;
		cmd.op = stp_pkg::OP_NONE;
		cmd.key = key_q;
		cmd.delay = delay_q;
		cmd.timeout = timeout_q;
		cmd.tick = tick_q;
		cmd.prod = mode_q;
		cmd.state = stp_pkg::ST_IDLE;
		cmd.sel = sel_idx;
		unique case (st_q)
			stp_pkg::FSM_IDLE: if (s_tvalid) begin
				st_d = (s_tdata[2:0] == stp_pkg::FN_OPEN) ? stp_pkg::FSM_DIV :
					(s_tdata[2:0] == stp_pkg::FN_TICK) ? stp_pkg::FSM_SCAN :
					stp_pkg::FSM_APPLY;
			end
			stp_pkg::FSM_DIV: st_d = stp_pkg::FSM_MUL;
			stp_pkg::FSM_MUL: st_d = stp_pkg::FSM_SCAN;
			stp_pkg::FSM_SCAN: begin
				cmd.op = stp_pkg::OP_SCAN;
				if (cnt_q == 6'(stp_pkg::TimerCount - 1)) st_d = stp_pkg::FSM_APPLY;
			end
			stp_pkg::FSM_APPLY: begin
				if (func_q == stp_pkg::FN_TICK) begin
					st_d = (due_q != 8'd0) ? stp_pkg::FSM_EVENT : stp_pkg::FSM_IDLE;
				end else begin
					st_d = stp_pkg::FSM_REPLY;
				end
				if (func_q == stp_pkg::FN_OPEN && delay_q != 0 && key_q != 0) begin
					if (hit_q) begin
						cmd.sel = hit_slot_q;
						if (!mode_q) cmd.op = stp_pkg::OP_RESTART;
					end else if (idle_q) begin
						cmd.sel = idle_slot_q;
						cmd.op = stp_pkg::OP_WRITE_NEW;
					end
				end else if (func_q == stp_pkg::FN_PAUSE && hnd_ok
						&& sel_view.state == stp_pkg::ST_RUNNING) begin
					cmd.op = stp_pkg::OP_SET_STATE;
					cmd.state = stp_pkg::ST_PAUSED;
				end else if (func_q == stp_pkg::FN_RESUME && hnd_ok
						&& sel_view.state == stp_pkg::ST_PAUSED) begin
					cmd.op = stp_pkg::OP_SET_STATE;
					cmd.state = stp_pkg::ST_RUNNING;
				end else if (func_q == stp_pkg::FN_STOP && si_ok
						&& sel_view.state == stp_pkg::ST_RUNNING) begin
					cmd.op = stp_pkg::OP_CLEAR;
				end else if (func_q == stp_pkg::FN_CANCEL && hnd_ok
						&& sel_view.state != stp_pkg::ST_RUNNING) begin
					cmd.op = stp_pkg::OP_CLEAR;
				end
			end
			stp_pkg::FSM_REPLY: if (m_tready) st_d = stp_pkg::FSM_IDLE;
			stp_pkg::FSM_EVENT: begin
				if (m_tready) begin
					cmd.sel = ev_slot;
					if (mode_q) begin
						cmd.op = stp_pkg::OP_RESTART;
					end else begin
						cmd.op = stp_pkg::OP_SET_STATE;
						cmd.state = stp_pkg::ST_PAUSED;
					end
					if (!more_ev) st_d = stp_pkg::FSM_IDLE;
				end
			end
			default: st_d = stp_pkg::FSM_IDLE;
		endcase
	end

	assign m_tvalid = (st_q == stp_pkg::FSM_REPLY) || (st_q == stp_pkg::FSM_EVENT);
	assign m_tuser = (st_q == stp_pkg::FSM_EVENT);
	assign m_tlast = (st_q == stp_pkg::FSM_REPLY) || !more_ev;
	always_comb begin
		if (st_q == stp_pkg::FSM_EVENT)
			m_tdata = {1'b0, ev_slot, 4'd0, stp_pkg::StatusOk};
		else
			m_tdata = {1'b0, 3'd0, rh_q, status_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= stp_pkg::FSM_IDLE;
			tick_q <= '0;
			cnt_q <= '0;
			due_q <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				stp_pkg::FSM_IDLE: if (s_tvalid) begin
					func_q <= s_tdata[2:0];
					delay_q <= s_tdata[34:3];
					key_q <= s_tdata[50:35];
					hnd_q <= s_tdata[54:51];
					si_q <= s_tdata[58:55];
					mode_q <= prod;
					cnt_q <= '0;
					quot_q <= '0;
					hit_q <= 1'b0;
					idle_q <= 1'b0;
					due_q <= '0;
					if (s_tdata[2:0] == stp_pkg::FN_TICK) tick_q <= tick_q + 32'd1;
				end
				stp_pkg::FSM_DIV: begin
					quot_q <= 32'(recip_prod >> stp_pkg::MsRecipShift);
				end
				stp_pkg::FSM_MUL: begin
					timeout_q <= 32'(ticks_per_second * (mode_q ? quot_q : stp_pkg::DevSeconds));
				end
				stp_pkg::FSM_SCAN: begin
					cnt_q <= cnt_q + 6'd1;
					if (func_q == stp_pkg::FN_TICK) begin
						if (head.state == stp_pkg::ST_RUNNING
								&& (tick_q - head.start) >= head.timeout)
							due_q[head_id] <= 1'b1;
					end else begin
						if (!hit_q && head.client == key_q
								&& (head.state == stp_pkg::ST_RUNNING
								|| (!mode_q && head.state == stp_pkg::ST_PAUSED))) begin
							hit_q <= 1'b1;
							hit_slot_q <= head_id;
						end
						if (head.state == stp_pkg::ST_IDLE
								&& (!idle_q || head_id < idle_slot_q)) begin
							idle_q <= 1'b1;
							idle_slot_q <= head_id;
						end
						if (head.client == key_q && hit_q && head_id < hit_slot_q
								&& (head.state == stp_pkg::ST_RUNNING
								|| (!mode_q && head.state == stp_pkg::ST_PAUSED)))
							hit_slot_q <= head_id;
					end
				end
				stp_pkg::FSM_APPLY: begin
					status_q <= stp_pkg::StatusOk;
					rh_q <= '0;
					unique case (func_q)
						stp_pkg::FN_TICK: begin
						end
						stp_pkg::FN_OPEN: begin
							if (delay_q == 0 || key_q == 0) status_q <= stp_pkg::StatusBad;
							else if (hit_q) rh_q <= {1'b0, hit_slot_q} + 4'd1;
							else if (idle_q) rh_q <= {1'b0, idle_slot_q} + 4'd1;
							else status_q <= stp_pkg::StatusNoFree;
						end
						stp_pkg::FN_PAUSE, stp_pkg::FN_RESUME, stp_pkg::FN_CANCEL:
							if (!hnd_ok) status_q <= stp_pkg::StatusBad;
						stp_pkg::FN_STOP: if (!si_ok) status_q <= stp_pkg::StatusBad;
						default: status_q <= stp_pkg::StatusBad;
					endcase
				end
				stp_pkg::FSM_EVENT: if (m_tready) due_q[ev_slot] <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	logic unused_c;
	assign unused_c = s_tdata[59];

	chk_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == stp_pkg::FSM_EVENT && m_tready && !more_ev) |=> st_q == stp_pkg::FSM_IDLE)
		else $error("event run did not close");
	chk_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[2:0] == stp_pkg::FN_TICK)
		|=> tick_q == $past(tick_q) + 32'd1)
		else $error("tick count did not advance");
	chk_ev: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == stp_pkg::FSM_EVENT) |-> due_q != 8'd0)
		else $error("event with nothing due");

endmodule

FILE: rtl/core/software_timer_pool.sv
// Top level of the timer pool: register port, controller and slot chain.
// Requests are handled one at a time. A tick or open walks the eight-slot
// chain, one slot per cycle; open first gets whole seconds of the delay by
// a reciprocal multiply (DIV state) and then scales them to ticks (MUL
// state). Replies and expiry events wait while the output is stalled.
module software_timer_pool (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// func[2:0] delay_ms[34:3] client_key[50:35] handle[54:51] slot_index[58:55]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0] result_handle[5:2] expired_slot[8:6]
	output logic [15:0] m_tdata,
	// kind
	output logic        m_tuser,
	output logic        m_tlast
);

	logic [31:0] tps_q;
	logic        prod_q;
	stp_pkg::cell_cmd_t cmd;
	stp_pkg::cell_view_t views [stp_pkg::TimerCount];
	logic [stp_pkg::SlotW-1:0] ids [stp_pkg::TimerCount];
	logic [stp_pkg::SlotW-1:0] sel_idx;
	stp_pkg::cell_view_t sel_view;
	logic [9:0] td;

	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			1'b0: prdata = tps_q;
			1'b1: prdata = {31'd0, prod_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= 32'd1000;
			prod_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2:2] == stp_pkg::RegTicks[0:0] && paddr[1:0] == 2'd0)
				tps_q <= pwdata;
			else if (paddr[2:2] == stp_pkg::RegMode[0:0] && paddr[1:0] == 2'd0)
				prod_q <= pwdata[0];
		end
	end

	// Outside a scan the chain rests with slot i in cell i.
	assign sel_view = views[sel_idx];

	stp_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata(s_tdata[59:0]),
		.m_tvalid, .m_tready, .m_tdata(td), .m_tlast, .m_tuser,
		.ticks_per_second(tps_q), .prod(prod_q),
		.head(views[0]), .head_id(ids[0]), .sel_view, .cmd, .sel_idx
	);
	assign m_tdata = {6'd0, td};

	for (genvar i = 0; i < stp_pkg::TimerCount; i++) begin : g_cell
		stp_cell u_cell (
			.clk, .arst_n, .cmd, .idx(stp_pkg::SlotW'(i)),
			.prev(views[(i + 1) % stp_pkg::TimerCount]),
			.prev_id(ids[(i + 1) % stp_pkg::TimerCount]),
			.view(views[i]), .view_id(ids[i])
		);
	end

	logic unused_t;
	assign unused_t = ^s_tdata[63:60];

endmodule
